// ----- rtl/rbb_pkg.sv -----
// Shared constants, job type and helper functions of the RGB 3x3 box blur.
package rbb_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int AW        = $clog2(3 * MAX_WIDTH);
  localparam int HW        = 16;
  localparam int FWW       = 11;
  localparam int CFG_DW    = 16;
  localparam int CFG_IW    = 2;
  localparam int QDEPTH    = 4;
  localparam int QPW       = $clog2(QDEPTH);
  localparam int SW        = 12;
  localparam int MW        = 17;

  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // One unit of work for the back end: optional store write and optional blur.
  typedef struct packed {
    logic          wr;
    logic          col0;
    logic          emit;
    logic [AW-1:0] waddr;
    logic [23:0]   px;
    logic [1:0]    orm;
    logic [CW-1:0] ocol;
    logic          top;
    logic          bot;
    logic          lft;
    logic          rgt;
    logic          last;
  } rbb_job_t;

  // Line store address of a row slot and column.
  function automatic logic [AW-1:0] slot_addr(input logic [1:0] rm, input logic [CW-1:0] col);
    slot_addr = AW'(rm) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  // Reciprocal scaled by 2^16, rounded up; exact for sums below 2304.
  function automatic logic [MW-1:0] recip(input logic [3:0] n);
    case (n)
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd6:    recip = 17'd10923;
      4'd9:    recip = 17'd7282;
      default: recip = 17'd65536;
    endcase
  endfunction

endpackage

// ----- rtl/rbb_front.sv -----
// Front end: takes items, tracks frame positions and issues jobs.
module rbb_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rbb_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [rbb_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic [7:0]               red_i,
  input  logic [7:0]               green_i,
  input  logic [7:0]               blue_i,
  input  logic                     full_i,
  output logic                     push_o,
  output rbb_pkg::rbb_job_t        job_o
);

  logic [rbb_pkg::FWW-1:0] fw_q;
  logic [rbb_pkg::HW-1:0]  fh_q;
  logic [rbb_pkg::CW-1:0]  icol_q, icol_d, ocol_q, ocol_d;
  logic [rbb_pkg::HW-1:0]  irow_q, irow_d, orow_q, orow_d;
  logic [1:0]              irm_q, irm_d, orm_q, orm_d;
  logic                    recv_q, recv_d;
  logic [rbb_pkg::WW-1:0]  eff_w;
  logic [rbb_pkg::HW-1:0]  eff_h;
  logic                    acc, due, o_last, i_col_end, i_row_end;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;

  // Clamp the frame size registers.
  always_comb begin
    if (fw_q == '0) begin
      eff_w = rbb_pkg::WW'(1);
    end else if (32'(fw_q) > rbb_pkg::MAX_WIDTH) begin
      eff_w = rbb_pkg::WW'(rbb_pkg::MAX_WIDTH);
    end else begin
      eff_w = rbb_pkg::WW'(fw_q);
    end
    eff_h = (fh_q == '0) ? rbb_pkg::HW'(1) : fh_q;
  end

  assign due       = (irow_q >= rbb_pkg::HW'(2)) || (irow_q == rbb_pkg::HW'(1) && icol_q != '0);
  assign o_last    = (32'(orow_q) + 32'd1 >= 32'(eff_h)) && (32'(ocol_q) + 32'd1 >= 32'(eff_w));
  assign i_col_end = 32'(icol_q) + 32'd1 >= 32'(eff_w);
  assign i_row_end = 32'(irow_q) + 32'd1 >= 32'(eff_h);

  // Build the job and the next positions.
  always_comb begin
    icol_d = icol_q;
    irow_d = irow_q;
    irm_d  = irm_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    orm_d  = orm_q;
    recv_d = recv_q;
    push_o = 1'b0;

    job_o.wr    = 1'b0;
    job_o.col0  = (icol_q == '0);
    job_o.emit  = 1'b0;
    job_o.waddr = rbb_pkg::slot_addr(irm_q, icol_q);
    job_o.px    = {red_i, green_i, blue_i};
    job_o.orm   = orm_q;
    job_o.ocol  = ocol_q;
    job_o.top   = (orow_q != '0);
    job_o.bot   = 32'(orow_q) + 32'd1 < 32'(eff_h);
    job_o.lft   = (ocol_q != '0);
    job_o.rgt   = 32'(ocol_q) + 32'd1 < 32'(eff_w);
    job_o.last  = o_last;

    if (acc) begin
      if (cmd_i == rbb_pkg::CMD_PIXEL && !recv_q) begin
        push_o     = 1'b1;
        job_o.wr   = 1'b1;
        job_o.emit = due;
        // advance the input position
        if (i_col_end) begin
          icol_d = '0;
          irm_d  = (irm_q == 2'd2) ? 2'd0 : irm_q + 2'd1;
          if (i_row_end) begin
            irow_d = '0;
            irm_d  = 2'd0;
            recv_d = 1'b1;
          end else begin
            irow_d = irow_q + rbb_pkg::HW'(1);
          end
        end else begin
          icol_d = icol_q + rbb_pkg::CW'(1);
        end
      end else if (cmd_i == rbb_pkg::CMD_DRAIN && recv_q) begin
        push_o     = 1'b1;
        job_o.emit = 1'b1;
      end
      // advance the output position on every blur
      if (push_o && job_o.emit) begin
        if (o_last) begin
          icol_d = '0;
          irow_d = '0;
          irm_d  = 2'd0;
          ocol_d = '0;
          orow_d = '0;
          orm_d  = 2'd0;
          recv_d = 1'b0;
        end else if (32'(ocol_q) + 32'd1 >= 32'(eff_w)) begin
          ocol_d = '0;
          orow_d = orow_q + rbb_pkg::HW'(1);
          orm_d  = (orm_q == 2'd2) ? 2'd0 : orm_q + 2'd1;
        end else begin
          ocol_d = ocol_q + rbb_pkg::CW'(1);
        end
      end
    end

    // a register write abandons the frame
    if (cfg_we_i && (cfg_index_i == rbb_pkg::CFG_FRAME_WIDTH ||
                     cfg_index_i == rbb_pkg::CFG_FRAME_HEIGHT)) begin
      icol_d = '0;
      irow_d = '0;
      irm_d  = 2'd0;
      ocol_d = '0;
      orow_d = '0;
      orm_d  = 2'd0;
      recv_d = 1'b0;
    end
  end

  // Hold registers and positions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= rbb_pkg::FWW'(640);
      fh_q   <= rbb_pkg::HW'(480);
      icol_q <= '0;
      irow_q <= '0;
      irm_q  <= 2'd0;
      ocol_q <= '0;
      orow_q <= '0;
      orm_q  <= 2'd0;
      recv_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == rbb_pkg::CFG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i[rbb_pkg::FWW-1:0];
      end
      if (cfg_we_i && cfg_index_i == rbb_pkg::CFG_FRAME_HEIGHT) begin
        fh_q <= cfg_data_i[rbb_pkg::HW-1:0];
      end
      icol_q <= icol_d;
      irow_q <= irow_d;
      irm_q  <= irm_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      orm_q  <= orm_d;
      recv_q <= recv_d;
    end
  end

endmodule

// ----- rtl/rbb_fifo.sv -----
// Short job queue between the front and back ends.
module rbb_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rbb_pkg::rbb_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rbb_pkg::rbb_job_t job_o
);

  rbb_pkg::rbb_job_t       mem_q [rbb_pkg::QDEPTH];
  logic [rbb_pkg::QPW-1:0] wp_q, rp_q;
  logic [rbb_pkg::QPW:0]   cnt_q;

  assign full_o  = (cnt_q == (rbb_pkg::QPW+1)'(rbb_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];

  // Store the entry.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + rbb_pkg::QPW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + rbb_pkg::QPW'(1);
      end
      cnt_q <= cnt_q + (rbb_pkg::QPW+1)'(push_i) - (rbb_pkg::QPW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

// ----- rtl/rbb_back.sv -----
// Back end: line store, neighbourhood sum and scaling of one job at a time.
module rbb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rbb_pkg::rbb_job_t job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic              frame_end_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_RD, ST_LAST, ST_MUL, ST_OUT, ST_POST
  } state_e;

  localparam int PW = rbb_pkg::SW + rbb_pkg::MW;

  state_e                  state_q;
  rbb_pkg::rbb_job_t       job_q;
  logic [23:0]             mem [3 * rbb_pkg::MAX_WIDTH];
  logic [23:0]             rdata_q;
  logic                    rvalid_q;
  logic [1:0]              dr_q, dc_q;
  logic [rbb_pkg::SW-1:0]  sr_q, sg_q, sb_q;
  logic [PW-1:0]           pr_q, pg_q, pb_q;
  logic                    tap_ok, we;
  logic [1:0]              row_sel;
  logic [rbb_pkg::CW-1:0]  col;
  logic [rbb_pkg::AW-1:0]  raddr;
  logic [3:0]              n;
  logic [rbb_pkg::MW-1:0]  m;

  assign pop_o       = (state_q == ST_IDLE) && valid_i;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_red_o   = pr_q[23:16];
  assign out_green_o = pg_q[23:16];
  assign out_blue_o  = pb_q[23:16];
  assign frame_end_o = job_q.last;

  // Select the tap of the neighbourhood.
  always_comb begin
    tap_ok = (dr_q != 2'd0 || job_q.top) && (dr_q != 2'd2 || job_q.bot) &&
             (dc_q != 2'd0 || job_q.lft) && (dc_q != 2'd2 || job_q.rgt);
    case (dr_q)
      2'd0:    row_sel = (job_q.orm == 2'd0) ? 2'd2 : job_q.orm - 2'd1;
      2'd2:    row_sel = (job_q.orm == 2'd2) ? 2'd0 : job_q.orm + 2'd1;
      default: row_sel = job_q.orm;
    endcase
    col   = job_q.ocol + rbb_pkg::CW'(dc_q) - rbb_pkg::CW'(1);
    raddr = rbb_pkg::slot_addr(row_sel, col);
    n     = (4'd1 + 4'(job_q.top) + 4'(job_q.bot)) * (4'd1 + 4'(job_q.lft) + 4'(job_q.rgt));
    m     = rbb_pkg::recip(n);
    we    = job_q.wr && ((state_q == ST_PRE && !job_q.col0) ||
                         (state_q == ST_POST && job_q.col0));
  end

  // Write and read the line store.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[job_q.waddr] <= job_q.px;
    end
    rdata_q <= mem[raddr];
  end

  // Step through a job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
      dr_q     <= 2'd0;
      dc_q     <= 2'd0;
    end else begin
      rvalid_q <= (state_q == ST_RD) && tap_ok;
      if (rvalid_q) begin
        sr_q <= sr_q + rbb_pkg::SW'(rdata_q[23:16]);
        sg_q <= sg_q + rbb_pkg::SW'(rdata_q[15:8]);
        sb_q <= sb_q + rbb_pkg::SW'(rdata_q[7:0]);
      end
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            job_q   <= job_i;
            state_q <= ST_PRE;
          end
        end
        ST_PRE: begin
          sr_q <= '0;
          sg_q <= '0;
          sb_q <= '0;
          dr_q <= 2'd0;
          dc_q <= 2'd0;
          state_q <= job_q.emit ? ST_RD : ST_POST;
        end
        ST_RD: begin
          if (dc_q == 2'd2) begin
            dc_q <= 2'd0;
            if (dr_q == 2'd2) begin
              state_q <= ST_LAST;
            end else begin
              dr_q <= dr_q + 2'd1;
            end
          end else begin
            dc_q <= dc_q + 2'd1;
          end
        end
        ST_LAST: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          pr_q    <= PW'(sr_q) * PW'(m);
          pg_q    <= PW'(sg_q) * PW'(m);
          pb_q    <= PW'(sb_q) * PW'(m);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_PRE || state_q == ST_POST)) else $error("write outside phase");
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(state_q) == ST_RD) else $error("stray read data");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pr_q)) else $error("beat dropped");

endmodule

// ----- rtl/rgb_box_blur_3x3.sv -----
// Streaming 3x3 box blur of RGB frames: front end, job queue, back end.
// Throughput is set by the back end, which handles one job at a time and reads the
// nine taps of a blurring item one a cycle from the line store; a store-only pixel
// only writes the store.
// Up to four jobs queue, so input beats are taken while a result waits.
// Reset: asynchronous, active low; 640x480 frame, position counters cleared.
module rgb_box_blur_3x3 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbb_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [rbb_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_red_o,
  output logic [7:0]                 out_green_o,
  output logic [7:0]                 out_blue_o,
  output logic                       frame_end_o
);

  rbb_pkg::rbb_job_t push_job, pop_job;
  logic              push, full, pop, qvalid;

  rbb_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .red_i, .green_i, .blue_i,
    .full_i (full), .push_o (push), .job_o (push_job)
  );

  rbb_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push), .job_i (push_job), .full_o (full),
    .pop_i (pop), .valid_o (qvalid), .job_o (pop_job)
  );

  rbb_back u_back (
    .clk_i, .rst_ni,
    .valid_i (qvalid), .job_i (pop_job), .pop_o (pop),
    .out_valid_o, .out_ready_i, .out_red_o, .out_green_o, .out_blue_o, .frame_end_o
  );

endmodule

// ----- tb/sv/rgb_box_blur_3x3_test.sv -----
// Self-checking testbench of the RGB 3x3 box blur: framed stimulus and scoreboard.
module rgb_box_blur_3x3_test;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } blur_px_t;

  // Predicts blurred pixels and checks the block's beats against them.
  class blur_board;
    logic [23:0]  lines[3*rbb_pkg::MAX_WIDTH];
    int unsigned  in_col, in_row, out_col, out_row;
    bit           frame_in;
    logic [10:0]  fw;
    logic [15:0]  fh;
    blur_px_t     pending[$];
    int           errors;

    function new();
      fw = 11'd640;
      fh = 16'd480;
      errors = 0;
      clear_pos();
    endfunction

    function void clear_pos();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_in = 0;
    endfunction

    function int unsigned width_eff();
      if (fw == 0) return 1;
      if (fw > rbb_pkg::MAX_WIDTH) return rbb_pkg::MAX_WIDTH;
      return fw;
    endfunction

    function int unsigned height_eff();
      return (fh == 0) ? 1 : fh;
    endfunction

    function int unsigned slot_of(int unsigned row, int unsigned col);
      return ((row % 3) * rbb_pkg::MAX_WIDTH + col) % (3 * rbb_pkg::MAX_WIDTH);
    endfunction

    function void set_reg(logic [rbb_pkg::CFG_IW-1:0] idx, logic [rbb_pkg::CFG_DW-1:0] val);
      if (idx == rbb_pkg::CFG_FRAME_WIDTH) fw = val[10:0];
      else if (idx == rbb_pkg::CFG_FRAME_HEIGHT) fh = val;
      else return;
      clear_pos();
    endfunction

    // Average the in-frame neighbours of the next output position and advance.
    function void blur_next();
      int unsigned w, h, sr, sg, sb, n, rr, cc;
      logic [23:0] px;
      blur_px_t e;
      w = width_eff(); h = height_eff();
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if ((dr < 0 && out_row == 0) || (dr > 0 && out_row + 1 >= h)) continue;
          if ((dc < 0 && out_col == 0) || (dc > 0 && out_col + 1 >= w)) continue;
          rr = out_row + dr; cc = out_col + dc;
          px = lines[slot_of(rr, cc)];
          sr += px[23:16]; sg += px[15:8]; sb += px[7:0];
          n++;
        end
      end
      if (n == 0) n = 1;
      e.r = 8'(sr / n); e.g = 8'(sg / n); e.b = 8'(sb / n);
      e.fe = (out_row + 1 >= h) && (out_col + 1 >= w);
      pending.push_back(e);
      if (e.fe) begin
        clear_pos();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    endfunction

    // Note one accepted input beat.
    function void note_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h;
      bit due;
      w = width_eff(); h = height_eff();
      if (cmd == rbb_pkg::CMD_DRAIN) begin
        if (frame_in) blur_next();
        return;
      end
      if (frame_in) return;
      due = in_row >= 2 || (in_row == 1 && in_col >= 1);
      // column 0 slot may still be read by the due output
      if (in_col != 0) lines[slot_of(in_row, in_col)] = {r, g, b};
      if (due) blur_next();
      if (in_col == 0) lines[slot_of(in_row, in_col)] = {r, g, b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_in = 1;
        end
      end
    endfunction

    // Compare one output beat with the oldest expected pixel.
    function void check_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      blur_px_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat r=%0d g=%0d b=%0d", r, g, b);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.r) begin $error("out_red expected %0d got %0d", e.r, r); errors++; end
      if (g !== e.g) begin $error("out_green expected %0d got %0d", e.g, g); errors++; end
      if (b !== e.b) begin $error("out_blue expected %0d got %0d", e.b, b); errors++; end
      if (fe !== e.fe) begin
        $error("frame_end expected %0d got %0d", e.fe, fe);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [rbb_pkg::CFG_IW-1:0]  cfg_index_i = rbb_pkg::CFG_FRAME_WIDTH;
  logic [rbb_pkg::CFG_DW-1:0]  cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        cmd_i = rbb_pkg::CMD_PIXEL;
  logic [7:0]                  red_i = '0, green_i = '0, blue_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [7:0]                  out_red_o, out_green_o, out_blue_o;
  logic                        frame_end_o;

  blur_board board = new();
  int                cycles = 0;
  int                items = 0;
  int                send_idle = 0;
  int                recv_stall = 0;

  rgb_box_blur_3x3 DUT (.*);

  always #6 clk_i = ~clk_i;

  // Stall the receiver at the current rate and check each output beat.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall);
    if (out_valid_o && out_ready_i)
      board.check_px(out_red_o, out_green_o, out_blue_o, frame_end_o);
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one beat, idling first at the sender rate, and hold it until taken.
  task automatic send(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd; red_i <= r; green_i <= g; blue_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(cmd, r, g, b);
    items++;
  endtask

  // Drop valid and wait until every expected pixel is out and the block is quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rbb_pkg::CFG_IW-1:0] idx, logic [rbb_pkg::CFG_DW-1:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] chan();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one frame with noise; stop after limit pixels when limit is nonzero.
  task automatic run_frame(logic [rbb_pkg::CFG_DW-1:0] w, logic [rbb_pkg::CFG_DW-1:0] h,
                           int limit);
    int npix;
    settle();
    write_reg(rbb_pkg::CFG_FRAME_WIDTH, w);
    write_reg(rbb_pkg::CFG_FRAME_HEIGHT, h);
    recv_stall = 0; send_idle = 0;
    case ($urandom_range(3))
      1: send_idle = 56;
      2: recv_stall = 56;
      3: begin send_idle = 7; recv_stall = 7; end
      default: ;
    endcase
    npix = board.width_eff() * board.height_eff();
    if (limit != 0 && limit < npix) npix = limit;
    for (int i = 0; i < npix; i++) begin
      // early drain is ignored
      if ($urandom_range(19) == 0) send(rbb_pkg::CMD_DRAIN, chan(), chan(), chan());
      send(rbb_pkg::CMD_PIXEL, chan(), chan(), chan());
    end
    if (limit != 0) return;
    while (board.frame_in) begin
      // pixel during drain is ignored
      if ($urandom_range(19) == 0) send(rbb_pkg::CMD_PIXEL, chan(), chan(), chan());
      else send(rbb_pkg::CMD_DRAIN, chan(), chan(), chan());
    end
    if ($urandom_range(4) == 0) send(rbb_pkg::CMD_DRAIN, chan(), chan(), chan());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed shapes: interior, single pixel, thin frames, zero sizes, clamped row
    run_frame(3, 3, 0);
    run_frame(1, 1, 0);
    run_frame(1, 4, 0);
    run_frame(4, 1, 0);
    run_frame(2, 2, 0);
    run_frame(0, 0, 0);
    run_frame(5, 3, 0);
    run_frame(16'hF803, 2, 0);
    run_frame(1, 65535, 20);
    run_frame(2047, 2, 1027);
    // hold off until the block has emptied once
    settle();
    while (items < 1150) begin
      run_frame($urandom_range(9) == 0 ? rbb_pkg::CFG_DW'($urandom_range(12))
                                       : rbb_pkg::CFG_DW'($urandom_range(1, 8)),
                $urandom_range(9) == 0 ? rbb_pkg::CFG_DW'($urandom_range(8))
                                       : rbb_pkg::CFG_DW'($urandom_range(1, 6)), 0);
    end
    settle();
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
